>>> sv/civil_date_day_number_converter_defines.svh
// Assertion macros for the civil date / day number converter.
// Included by the top level; uses no other file.
`ifndef CIVIL_DATE_DAY_NUMBER_CONVERTER_DEFINES_SVH
`define CIVIL_DATE_DAY_NUMBER_CONVERTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDDN_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define CDDN_ASSERT_LATER(name, clk, rst, ante, dly, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

>>> sv/cddn_pkg.sv
// Types, constants and small calendar tables for the civil date converter.
// Depends on nothing; imported by the top level.
package cddn_pkg;

   typedef logic signed [24:0] day_number_type;
   typedef logic signed [15:0] year_type;
   typedef logic [3:0]         month_type;
   typedef logic [4:0]         mday_type;

   // Direction codes.
   localparam logic FUNC_TO_DAYS  = 1'b0;
   localparam logic FUNC_TO_CIVIL = 1'b1;

   // Cycles from an accepted request beat to the edge that takes its result.
   localparam int LATENCY = 13;
   // Stages that hold the civil-to-days result until the other path catches up.
   localparam int CIV_DELAY = 5;

   localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
   localparam logic [17:0] DAYS_PER_YEAR = 18'd365;
   // Offset from 1970-01-01 to 0000-03-01 (719468) plus 110 eras, so that the
   // shifted day count is never negative.
   localparam logic [26:0] DAY_BIAS      = 27'd16790138;
   localparam logic [7:0]  DAY_ERA_BIAS  = 8'd110;
   // 82 eras of years keep the shifted civil year positive.
   localparam logic [17:0] YEAR_BIAS     = 18'd32800;
   // 719468 plus 82 eras of days.
   localparam logic [25:0] CIV_DAY_BIAS  = 26'd12699422;
   // 110 eras expressed in years.
   localparam logic [18:0] DAY_YEAR_BIAS = 19'd44000;

   // Reciprocals for division by constants; each estimate is low by at most one.
   localparam logic [11:0] RECIP_25     = 12'd2621;    // 2^16 / 25
   localparam logic [16:0] RECIP_ERA    = 17'd117592;  // 2^34 / 146097
   localparam logic [17:0] RECIP_365    = 18'd183859;  // 2^26 / 365

   // First day of each month in a year that starts on March 1.
   function automatic logic [8:0] month_start(input logic [3:0] mi);
      logic [8:0] r;
      case (mi)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Length of a civil month in a common year; zero for a month that does not exist.
   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] r;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
         4'd2:                                       r = 5'd28;
         default:                                    r = 5'd0;
      endcase
      return r;
   endfunction

   // Number of whole centuries in a year of the era.
   function automatic logic [1:0] cent_count(input logic [8:0] yoe);
      return 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
   endfunction

endpackage

>>> sv/civil_date_day_number_converter.sv
// Civil date / day number converter, both directions, in a 13-stage pipeline.
// One request beat is accepted per cycle.
// busy stays low: constant divisions use reciprocal multiplies spread over the stages.
// Reset clears only the stage valid bits and the result strobe.
// Depends on cddn_pkg and civil_date_day_number_converter_defines.svh.
`include "civil_date_day_number_converter_defines.svh"

module civil_date_day_number_converter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_func,
   input  cddn_pkg::year_type       req_in_year,
   input  cddn_pkg::month_type      req_in_month,
   input  cddn_pkg::mday_type       req_in_day,
   input  cddn_pkg::day_number_type req_in_day_number,
   output logic                     rsp_strobe,
   output cddn_pkg::day_number_type rsp_out_day_number,
   output cddn_pkg::year_type       rsp_out_year,
   output cddn_pkg::month_type      rsp_out_month,
   output cddn_pkg::mday_type       rsp_out_day,
   output logic                     rsp_valid_res
);
   import cddn_pkg::*;

   // Control chain.
   logic        req_take;
   logic [11:0] vld_ff, vld_in;
   logic [11:0] fn_ff, fn_in;
   logic        strobe_ff, strobe_in;

   // Stage 1.
   logic [26:0] z_sum;
   logic [17:0] x_sum;
   logic        early;
   logic [3:0]  mi;
   logic [25:0] p1_zp_ff, p1_zp_in;
   logic [16:0] p1_x_ff, p1_x_in;
   logic [8:0]  p1_dofs_ff, p1_dofs_in;
   logic        p1_dok_ff, p1_dok_in, p1_f29_ff, p1_f29_in;
   // Stage 2.
   logic [42:0] p2_prodz_ff, p2_prodz_in;
   logic [25:0] p2_zp_ff;
   logic [24:0] p2_prodc_ff, p2_prodc_in;
   logic [16:0] p2_x_ff;
   logic [8:0]  p2_dofs_ff;
   logic        p2_dok_ff, p2_f29_ff;
   // Stage 3.
   logic [25:0] rz_full;
   logic [12:0] rc_full;
   logic [7:0]  p3_qz_ff, p3_qz_in, p3_qc_ff, p3_qc_in;
   logic [18:0] p3_rz_ff, p3_rz_in;
   logic [5:0]  p3_rc_ff, p3_rc_in;
   logic [16:0] p3_x_ff;
   logic [8:0]  p3_dofs_ff;
   logic        p3_dok_ff, p3_f29_ff;
   // Stage 4.
   logic [7:0]  p4_qz_ff, p4_qz_in, p4_qc_ff, p4_qc_in;
   logic [17:0] p4_doe_ff, p4_doe_in;
   logic [16:0] p4_x_ff;
   logic [8:0]  p4_dofs_ff;
   logic        p4_dok_ff, p4_f29_ff;
   // Stage 5.
   logic [16:0] yoe_full;
   logic [2:0]  c36;
   logic [33:0] p5_proda_ff, p5_proda_in;
   logic [17:0] p5_doe2_ff, p5_doe2_in, p5_doe_ff;
   logic [7:0]  p5_qz_ff, p5_qc_ff;
   logic [8:0]  p5_yoe_ff, p5_yoe_in, p5_dofs_ff;
   logic        p5_dok_ff, p5_f29_ff;
   // Stage 6.
   logic [15:0] ra_full;
   logic [9:0]  yoe_next;
   logic        leap;
   logic [6:0]  p6_qa_ff, p6_qa_in;
   logic [9:0]  p6_ra_ff, p6_ra_in;
   logic [17:0] p6_doe2_ff, p6_doe_ff;
   logic [7:0]  p6_qz_ff;
   logic [17:0] p6_cdoe_ff, p6_cdoe_in;
   logic [24:0] p6_eterm_ff, p6_eterm_in;
   logic        p6_cok_ff, p6_cok_in;
   // Stage 7.
   logic [25:0] cdn_sum;
   logic [6:0]  qa;
   logic [17:0] p7_x_ff, p7_x_in, p7_doe_ff;
   logic [7:0]  p7_qz_ff;
   logic [24:0] p7_cdn_ff, p7_cdn_in;
   logic        p7_cok_ff;
   // Stage 8.
   logic [35:0] p8_prodb_ff, p8_prodb_in;
   logic [17:0] p8_x_ff, p8_doe_ff;
   logic [7:0]  p8_qz_ff;
   // Stage 9.
   logic [17:0] rb_full;
   logic [8:0]  p9_qb_ff, p9_qb_in;
   logic [9:0]  p9_rb_ff, p9_rb_in;
   logic [17:0] p9_doe_ff;
   logic [7:0]  p9_qz_ff;
   // Stage 10.
   logic [8:0]  p10_yoe_ff, p10_yoe_in;
   logic [17:0] p10_doe_ff;
   logic [7:0]  p10_qz_ff;
   // Stage 11.
   logic [17:0] doy_full;
   logic [18:0] ybase_full;
   logic [8:0]  p11_doy_ff, p11_doy_in;
   logic [17:0] p11_ybase_ff, p11_ybase_in;
   // Stage 12.
   logic [3:0]  p12_mp_ff, p12_mp_in;
   logic [8:0]  p12_doy_ff;
   logic [17:0] p12_ybase_ff;
   // Civil-to-days result delay line, aligned with stage 12 at its end.
   logic [24:0]          civ_dn_ff [CIV_DELAY];
   logic [CIV_DELAY-1:0] civ_ok_ff;
   // Output stage.
   logic [17:0]    y_fin;
   logic [8:0]     d_full;
   logic           dok_fin;
   day_number_type out_dn_ff, out_dn_in;
   year_type       out_y_ff, out_y_in;
   month_type      out_m_ff, out_m_in;
   mday_type       out_d_ff, out_d_in;
   logic           out_ok_ff, out_ok_in;

   assign busy      = 1'b0;
   assign req_take  = start && !busy;
   assign vld_in    = {vld_ff[10:0], req_take};
   assign fn_in     = {fn_ff[10:0], req_func};
   assign strobe_in = vld_ff[11];

   always_comb begin
      // Stage 1: bias both inputs so that floor division becomes unsigned.
      z_sum      = {{2{req_in_day_number[24]}}, req_in_day_number} + DAY_BIAS;
      p1_zp_in   = z_sum[25:0];
      early      = (req_in_month <= 4'd2);
      x_sum      = {{2{req_in_year[15]}}, req_in_year} + YEAR_BIAS - {17'd0, early};
      p1_x_in    = x_sum[16:0];
      mi         = early ? (req_in_month + 4'd9) : (req_in_month - 4'd3);
      p1_dofs_in = month_start(mi) + {4'd0, req_in_day} - 9'd1;
      p1_dok_in  = (req_in_day != 5'd0) && (req_in_day <= month_len(req_in_month));
      p1_f29_in  = (req_in_month == 4'd2) && (req_in_day == 5'd29);

      // Stage 2: reciprocal products for the era quotients.
      p2_prodz_in = 43'(p1_zp_ff) * 43'(RECIP_ERA);
      p2_prodc_in = 25'(p1_x_ff[16:4]) * 25'(RECIP_25);

      // Stage 3: quotient estimates and their remainders.
      p3_qz_in = p2_prodz_ff[41:34];
      rz_full  = p2_zp_ff - 26'(p3_qz_in) * 26'(DAYS_PER_ERA);
      p3_rz_in = rz_full[18:0];
      p3_qc_in = p2_prodc_ff[23:16];
      rc_full  = p2_x_ff[16:4] - 13'(p3_qc_in) * 13'd25;
      p3_rc_in = rc_full[5:0];

      // Stage 4: one correction step finishes each era division.
      if (p3_rz_ff >= 19'(DAYS_PER_ERA)) begin
         p4_qz_in  = p3_qz_ff + 8'd1;
         p4_doe_in = 18'(p3_rz_ff - 19'(DAYS_PER_ERA));
      end else begin
         p4_qz_in  = p3_qz_ff;
         p4_doe_in = p3_rz_ff[17:0];
      end
      p4_qc_in = p3_qc_ff + 8'(p3_rc_ff >= 6'd25);

      // Stage 5.
      yoe_full    = p4_x_ff - 17'(p4_qc_ff) * 17'd400;
      p5_yoe_in   = yoe_full[8:0];
      p5_proda_in = 34'(p4_doe_ff[17:2]) * 34'(RECIP_365);
      c36 = 3'(p4_doe_ff >= 18'd36524) + 3'(p4_doe_ff >= 18'd73048)
          + 3'(p4_doe_ff >= 18'd109572) + 3'(p4_doe_ff >= 18'd146096);
      p5_doe2_in  = p4_doe_ff + 18'(c36) - 18'(p4_doe_ff == 18'd146096);

      // Stage 6: for February the civil year is the year of era plus one.
      yoe_next    = 10'(p5_yoe_ff) + 10'd1;
      leap        = (yoe_next[1:0] == 2'd0) && (yoe_next != 10'd100)
                 && (yoe_next != 10'd200) && (yoe_next != 10'd300);
      p6_cok_in   = p5_dok_ff || (p5_f29_ff && leap);
      p6_cdoe_in  = 18'(p5_yoe_ff) * DAYS_PER_YEAR + 18'(p5_yoe_ff[8:2])
                  - 18'(cent_count(p5_yoe_ff)) + 18'(p5_dofs_ff);
      p6_eterm_in = 25'(p5_qc_ff) * 25'(DAYS_PER_ERA);
      p6_qa_in    = p5_proda_ff[32:26];
      ra_full     = p5_doe_ff[17:2] - 16'(p6_qa_in) * 16'(DAYS_PER_YEAR);
      p6_ra_in    = ra_full[9:0];

      // Stage 7.
      cdn_sum   = 26'(p6_eterm_ff) + 26'(p6_cdoe_ff) - CIV_DAY_BIAS;
      p7_cdn_in = cdn_sum[24:0];
      qa        = p6_qa_ff + 7'(p6_ra_ff >= 10'd365);
      p7_x_in   = p6_doe2_ff - 18'(qa);

      // Stage 8.
      p8_prodb_in = 36'(p7_x_ff) * 36'(RECIP_365);

      // Stage 9.
      p9_qb_in = p8_prodb_ff[34:26];
      rb_full  = p8_x_ff - 18'(p9_qb_in) * DAYS_PER_YEAR;
      p9_rb_in = rb_full[9:0];

      // Stage 10.
      p10_yoe_in = p9_qb_ff + 9'(p9_rb_ff >= 10'd365);

      // Stage 11.
      doy_full     = p10_doe_ff - 18'(p10_yoe_ff) * DAYS_PER_YEAR - 18'(p10_yoe_ff[8:2])
                   + 18'(cent_count(p10_yoe_ff));
      p11_doy_in   = doy_full[8:0];
      ybase_full   = 19'(p10_qz_ff) * 19'd400 + 19'(p10_yoe_ff) - DAY_YEAR_BIAS;
      p11_ybase_in = ybase_full[17:0];

      // Stage 12: month index by comparing against the month starts.
      p12_mp_in = 4'd0;
      for (int k = 1; k < 12; k++) begin
         p12_mp_in = p12_mp_in + 4'(p11_doy_ff >= month_start(4'(k)));
      end

      // Output stage.
      y_fin   = p12_ybase_ff + 18'(p12_mp_ff >= 4'd10);
      d_full  = p12_doy_ff - month_start(p12_mp_ff) + 9'd1;
      dok_fin = (y_fin[17:15] == 3'b000);
      if (fn_ff[11] == FUNC_TO_DAYS) begin
         out_dn_in = civ_ok_ff[CIV_DELAY-1] ? civ_dn_ff[CIV_DELAY-1] : '0;
         out_y_in  = '0;
         out_m_in  = '0;
         out_d_in  = '0;
         out_ok_in = civ_ok_ff[CIV_DELAY-1];
      end else begin
         out_dn_in = '0;
         out_ok_in = dok_fin;
         if (dok_fin) begin
            out_y_in = y_fin[15:0];
            out_m_in = (p12_mp_ff < 4'd10) ? (p12_mp_ff + 4'd3) : (p12_mp_ff - 4'd9);
            out_d_in = d_full[4:0];
         end else begin
            out_y_in = '0;
            out_m_in = '0;
            out_d_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      fn_ff        <= fn_in;
      p1_zp_ff     <= p1_zp_in;
      p1_x_ff      <= p1_x_in;
      p1_dofs_ff   <= p1_dofs_in;
      p1_dok_ff    <= p1_dok_in;
      p1_f29_ff    <= p1_f29_in;
      p2_prodz_ff  <= p2_prodz_in;
      p2_zp_ff     <= p1_zp_ff;
      p2_prodc_ff  <= p2_prodc_in;
      p2_x_ff      <= p1_x_ff;
      p2_dofs_ff   <= p1_dofs_ff;
      p2_dok_ff    <= p1_dok_ff;
      p2_f29_ff    <= p1_f29_ff;
      p3_qz_ff     <= p3_qz_in;
      p3_rz_ff     <= p3_rz_in;
      p3_qc_ff     <= p3_qc_in;
      p3_rc_ff     <= p3_rc_in;
      p3_x_ff      <= p2_x_ff;
      p3_dofs_ff   <= p2_dofs_ff;
      p3_dok_ff    <= p2_dok_ff;
      p3_f29_ff    <= p2_f29_ff;
      p4_qz_ff     <= p4_qz_in;
      p4_doe_ff    <= p4_doe_in;
      p4_qc_ff     <= p4_qc_in;
      p4_x_ff      <= p3_x_ff;
      p4_dofs_ff   <= p3_dofs_ff;
      p4_dok_ff    <= p3_dok_ff;
      p4_f29_ff    <= p3_f29_ff;
      p5_proda_ff  <= p5_proda_in;
      p5_doe2_ff   <= p5_doe2_in;
      p5_doe_ff    <= p4_doe_ff;
      p5_qz_ff     <= p4_qz_ff;
      p5_qc_ff     <= p4_qc_ff;
      p5_yoe_ff    <= p5_yoe_in;
      p5_dofs_ff   <= p4_dofs_ff;
      p5_dok_ff    <= p4_dok_ff;
      p5_f29_ff    <= p4_f29_ff;
      p6_qa_ff     <= p6_qa_in;
      p6_ra_ff     <= p6_ra_in;
      p6_doe2_ff   <= p5_doe2_ff;
      p6_doe_ff    <= p5_doe_ff;
      p6_qz_ff     <= p5_qz_ff;
      p6_cdoe_ff   <= p6_cdoe_in;
      p6_eterm_ff  <= p6_eterm_in;
      p6_cok_ff    <= p6_cok_in;
      p7_x_ff      <= p7_x_in;
      p7_doe_ff    <= p6_doe_ff;
      p7_qz_ff     <= p6_qz_ff;
      p7_cdn_ff    <= p7_cdn_in;
      p7_cok_ff    <= p6_cok_ff;
      p8_prodb_ff  <= p8_prodb_in;
      p8_x_ff      <= p7_x_ff;
      p8_doe_ff    <= p7_doe_ff;
      p8_qz_ff     <= p7_qz_ff;
      p9_qb_ff     <= p9_qb_in;
      p9_rb_ff     <= p9_rb_in;
      p9_doe_ff    <= p8_doe_ff;
      p9_qz_ff     <= p8_qz_ff;
      p10_yoe_ff   <= p10_yoe_in;
      p10_doe_ff   <= p9_doe_ff;
      p10_qz_ff    <= p9_qz_ff;
      p11_doy_ff   <= p11_doy_in;
      p11_ybase_ff <= p11_ybase_in;
      p12_mp_ff    <= p12_mp_in;
      p12_doy_ff   <= p11_doy_ff;
      p12_ybase_ff <= p11_ybase_ff;
      civ_dn_ff[0] <= p7_cdn_ff;
      civ_ok_ff[0] <= p7_cok_ff;
      for (int i = 1; i < CIV_DELAY; i++) begin
         civ_dn_ff[i] <= civ_dn_ff[i-1];
         civ_ok_ff[i] <= civ_ok_ff[i-1];
      end
      out_dn_ff    <= out_dn_in;
      out_y_ff     <= out_y_in;
      out_m_ff     <= out_m_in;
      out_d_ff     <= out_d_in;
      out_ok_ff    <= out_ok_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_out_day_number = out_dn_ff;
   assign rsp_out_year       = out_y_ff;
   assign rsp_out_month      = out_m_ff;
   assign rsp_out_day        = out_d_ff;
   assign rsp_valid_res      = out_ok_ff;

   // Every request beat produces its result beat a fixed time later.
   `CDDN_ASSERT_LATER(a_latency, clock, reset, req_take, LATENCY, rsp_strobe, "result beat missing")
   // An invalid result carries all-zero fields.
   `CDDN_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_strobe && !rsp_valid_res, (rsp_out_day_number == '0) && (rsp_out_year == '0) && (rsp_out_month == '0) && (rsp_out_day == '0), "invalid result not zeroed")
   // A valid civil result is a real month and day in a non-negative year.
   `CDDN_ASSERT_IMPL(a_civil_range, clock, reset, rsp_strobe && rsp_valid_res && (rsp_out_month != '0), (rsp_out_month <= 4'd12) && (rsp_out_day != '0) && !rsp_out_year[15] && (rsp_out_day_number == '0), "civil result out of range")

endmodule

>>> tb/sv/civil_date_day_number_converter_tb.sv
// Self-checking testbench for the civil date / day number converter.
// Drives request beats in both directions, predicts every result and checks it.
// Depends on cddn_pkg and the civil_date_day_number_converter RTL.
module civil_date_day_number_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cddn_pkg::*;

   localparam longint DAYS_TO_EPOCH   = 719468;
   localparam longint DAYS_IN_ERA     = 146097;
   localparam longint YEAR_LIMIT      = 32767;
   // Day number of 0000-01-01, the first date whose year is not negative.
   localparam longint FIRST_YEAR_ZERO = -719528;
   localparam int     RANDOM_BEATS    = 1650;
   localparam int     DRAIN_LIMIT     = 2000;

   typedef struct {
      day_number_type day_number;
      year_type       year;
      month_type      month;
      mday_type       mday;
      logic           valid;
   } date_result_type;

   class date_conversion_scoreboard;
      date_result_type expected_conversions[$];
      int unsigned  error_count = 0;
      int unsigned  to_days_count = 0;
      int unsigned  to_civil_count = 0;
      int unsigned  valid_count = 0;

      static function bit is_leap_year(longint y);
         return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
      endfunction

      static function longint floor_div(longint a, longint b);
         longint q;
         q = a / b;
         if (a % b != 0 && a < 0) q = q - 1;
         return q;
      endfunction

      static function longint month_days(longint y, longint m);
         case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap_year(y) ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      // Day count of a date that is known to be real.
      static function longint days_from_civil(longint y, longint m, longint d);
         longint ya, era, yoe, mi, doy, doe;
         ya  = y - ((m <= 2) ? 1 : 0);
         era = floor_div(ya, 400);
         yoe = ya - era * 400;
         mi  = m + ((m > 2) ? -3 : 9);
         doy = (153 * mi + 2) / 5 + d - 1;
         doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
         return era * DAYS_IN_ERA + doe - DAYS_TO_EPOCH;
      endfunction

      static function date_result_type convert_date(logic f, year_type y, month_type m,
                                                    mday_type d, day_number_type dn);
         date_result_type r;
         longint cy, cm, cd, z, era, doe, yoe, doy, mp, dd, mm, yy, total;
         r = '{default: '0};
         if (f == FUNC_TO_DAYS) begin
            cy = longint'(y);
            cm = longint'(m);
            cd = longint'(d);
            if (cd >= 1 && cd <= month_days(cy, cm)) begin
               total = days_from_civil(cy, cm, cd);
               r.day_number = total[24:0];
               r.valid = 1'b1;
            end
         end else begin
            z   = longint'(dn) + DAYS_TO_EPOCH;
            era = floor_div(z, DAYS_IN_ERA);
            doe = z - era * DAYS_IN_ERA;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            dd  = doy - (153 * mp + 2) / 5 + 1;
            mm  = (mp < 10) ? mp + 3 : mp - 9;
            yy  = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
            if (yy >= 0 && yy <= YEAR_LIMIT && dd >= 1 && dd <= month_days(yy, mm)) begin
               r.year  = yy[15:0];
               r.month = mm[3:0];
               r.mday  = dd[4:0];
               r.valid = 1'b1;
            end
         end
         return r;
      endfunction

      function void note_request(logic f, year_type y, month_type m, mday_type d,
                                 day_number_type dn);
         expected_conversions.push_back(convert_date(f, y, m, d, dn));
         if (f == FUNC_TO_DAYS) to_days_count++;
         else to_civil_count++;
      endfunction

      function void check_result(date_result_type got);
         date_result_type exp_r;
         if (expected_conversions.size() == 0) begin
            $error("Result beat arrived with no request outstanding");
            error_count++;
            return;
         end
         exp_r = expected_conversions.pop_front();
         if (got.valid === 1'b1) valid_count++;
         if (got.day_number !== exp_r.day_number) begin
            $error("out_day_number mismatch: expected %0d, actual %0d",
                   exp_r.day_number, got.day_number);
            error_count++;
         end
         if (got.year !== exp_r.year) begin
            $error("out_year mismatch: expected %0d, actual %0d", exp_r.year, got.year);
            error_count++;
         end
         if (got.month !== exp_r.month) begin
            $error("out_month mismatch: expected %0d, actual %0d", exp_r.month, got.month);
            error_count++;
         end
         if (got.mday !== exp_r.mday) begin
            $error("out_day mismatch: expected %0d, actual %0d", exp_r.mday, got.mday);
            error_count++;
         end
         if (got.valid !== exp_r.valid) begin
            $error("valid_res mismatch: expected %0b, actual %0b", exp_r.valid, got.valid);
            error_count++;
         end
      endfunction

      function void check_drained();
         if (expected_conversions.size() != 0) begin
            $error("%0d expected results never arrived", expected_conversions.size());
            error_count++;
         end
      endfunction
   endclass

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           start = 1'b0;
   logic           busy;
   logic           req_func = FUNC_TO_DAYS;
   year_type       req_in_year = '0;
   month_type      req_in_month = '0;
   mday_type       req_in_day = '0;
   day_number_type req_in_day_number = '0;
   logic           rsp_strobe;
   day_number_type rsp_out_day_number;
   year_type       rsp_out_year;
   month_type      rsp_out_month;
   mday_type       rsp_out_day;
   logic           rsp_valid_res;

   date_conversion_scoreboard sb;
   longint last_valid_day;

   civil_date_day_number_converter dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_in_year        (req_in_year),
      .req_in_month       (req_in_month),
      .req_in_day         (req_in_day),
      .req_in_day_number  (req_in_day_number),
      .rsp_strobe         (rsp_strobe),
      .rsp_out_day_number (rsp_out_day_number),
      .rsp_out_year       (rsp_out_year),
      .rsp_out_month      (rsp_out_month),
      .rsp_out_day        (rsp_out_day),
      .rsp_valid_res      (rsp_valid_res)
   );

   always #5 clock = ~clock;

   // Values read right after the edge are the ones the block sampled at that edge.
   always @(posedge clock) begin
      date_result_type got;
      if (!reset && sb != null) begin
         if (start === 1'b1 && busy === 1'b0)
            sb.note_request(req_func, req_in_year, req_in_month, req_in_day,
                            req_in_day_number);
         if (rsp_strobe === 1'b1) begin
            got.day_number = rsp_out_day_number;
            got.year       = rsp_out_year;
            got.month      = rsp_out_month;
            got.mday       = rsp_out_day;
            got.valid      = rsp_valid_res;
            sb.check_result(got);
         end
      end
   end

   task automatic send_beat(input logic f, input year_type y, input month_type m,
                            input mday_type d, input day_number_type dn);
      start             <= 1'b1;
      req_func          <= f;
      req_in_year       <= y;
      req_in_month      <= m;
      req_in_day        <= d;
      req_in_day_number <= dn;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Idle cycles carry junk on the payload so that it is seen to be ignored.
   task automatic idle_gap(input bit allowed);
      if (!allowed) return;
      while ($urandom_range(99) < 37) begin
         start             <= 1'b0;
         req_func          <= 1'($urandom);
         req_in_year       <= year_type'($urandom);
         req_in_month      <= month_type'($urandom);
         req_in_day        <= mday_type'($urandom);
         req_in_day_number <= day_number_type'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic send_date(input longint y, input longint m, input longint d);
      send_beat(FUNC_TO_DAYS, year_type'(y), month_type'(m), mday_type'(d),
                day_number_type'($urandom));
   endtask

   task automatic send_day(input longint dn);
      send_beat(FUNC_TO_CIVIL, year_type'($urandom), month_type'($urandom),
                mday_type'($urandom), day_number_type'(dn));
   endtask

   task automatic send_random_beat();
      longint y, m, d, span;
      if ($urandom_range(1) == 0) begin
         if ($urandom_range(99) < 80) begin
            y = longint'(year_type'($urandom));
            m = longint'($urandom_range(1, 12));
            d = date_conversion_scoreboard::month_days(y, m);
            // Bias toward month ends, including the day just past the end.
            if ($urandom_range(99) < 20) d = d + longint'($urandom_range(1));
            else d = longint'($urandom_range(1, 32'(d)));
            send_date(y, m, d);
         end else begin
            send_date(longint'($urandom), longint'($urandom), longint'($urandom));
         end
      end else begin
         if ($urandom_range(99) < 70) begin
            span = last_valid_day - FIRST_YEAR_ZERO;
            send_day(FIRST_YEAR_ZERO + longint'($urandom_range(32'(span))));
         end else begin
            send_day(longint'(day_number_type'($urandom)));
         end
      end
   endtask

   initial begin
      int waited;
      sb = new();
      last_valid_day = date_conversion_scoreboard::days_from_civil(YEAR_LIMIT, 12, 31);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: field extremes, leap-year rules, bad dates and year limits.
      send_date(-32768, 1, 1);
      send_date(32767, 12, 31);
      send_date(1970, 1, 1);
      send_date(2000, 2, 29);
      send_date(1900, 2, 29);
      send_date(2004, 2, 29);
      send_date(-4, 2, 29);
      send_date(-1, 2, 29);
      send_date(2023, 0, 1);
      send_date(2023, 13, 5);
      send_date(-32768, 15, 31);
      send_date(2023, 4, 0);
      send_date(2023, 4, 31);
      send_date(2023, 1, 31);
      idle_gap(1'b1);
      send_day(0);
      send_day(-1);
      send_day(16777215);
      send_day(-16777216);
      send_day(-DAYS_TO_EPOCH);
      send_day(FIRST_YEAR_ZERO);
      send_day(FIRST_YEAR_ZERO - 1);
      send_day(last_valid_day);
      send_day(last_valid_day + 1);
      send_day(11016);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         idle_gap(i < 700 || i >= 1000);
         send_random_beat();
      end
      start <= 1'b0;

      waited = 0;
      while (sb.expected_conversions.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      sb.check_drained();

      $display("Checked %0d date-to-day-number and %0d day-number-to-date beats,",
               sb.to_days_count, sb.to_civil_count);
      $display("with %0d results flagged as real dates in range.", sb.valid_count);
      if (sb.error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
